@@ design/rcts_pkg.sv @@
// Shared types and constants for the RC charge-time sensor.
// Used by the register file, the sequencer and the top level; no dependencies.
package rcts_pkg;

	localparam int SMP_W     = 16;
	localparam int TMO_W     = 20;
	localparam int RES_W     = 30;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CALIB_COUNT   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DISCH_TICKS   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SETTLE_TICKS  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_GAP_TICKS     = 3'd5;

	localparam logic [SMP_W-1:0] RST_SAMPLE_COUNT  = 16'd100;
	localparam logic [SMP_W-1:0] RST_CALIB_COUNT   = 16'd200;
	localparam logic [TMO_W-1:0] RST_TIMEOUT_TICKS = 20'd100000;
	localparam logic [SMP_W-1:0] RST_DISCH_TICKS   = 16'd1000;
	localparam logic [SMP_W-1:0] RST_SETTLE_TICKS  = 16'd10;
	localparam logic [SMP_W-1:0] RST_GAP_TICKS     = 16'd500;

	typedef struct packed {
		logic [SMP_W-1:0] sample_count;
		logic [SMP_W-1:0] calib_sample_count;
		logic [TMO_W-1:0] timeout_ticks;
		logic [SMP_W-1:0] discharge_ticks;
		logic [SMP_W-1:0] settle_ticks;
		logic [SMP_W-1:0] gap_ticks;
	} cfg_t;

endpackage

@@ design/rcts_regs.sv @@
// APB configuration registers of the RC charge-time sensor.
// Depends on rcts_pkg for the register map, reset values and cfg_t.
module rcts_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rcts_pkg::APB_AW-1:0]  paddr,
	input  logic [rcts_pkg::APB_DW-1:0]  pwdata,
	output logic [rcts_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	output rcts_pkg::cfg_t               cfg
);
	import rcts_pkg::*;

	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;
	cfg_t                 cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[APB_AW-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_count       <= RST_SAMPLE_COUNT;
			cfg_q.calib_sample_count <= RST_CALIB_COUNT;
			cfg_q.timeout_ticks      <= RST_TIMEOUT_TICKS;
			cfg_q.discharge_ticks    <= RST_DISCH_TICKS;
			cfg_q.settle_ticks       <= RST_SETTLE_TICKS;
			cfg_q.gap_ticks          <= RST_GAP_TICKS;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SAMPLE_COUNT:  cfg_q.sample_count       <= pwdata[SMP_W-1:0];
				REG_CALIB_COUNT:   cfg_q.calib_sample_count <= pwdata[SMP_W-1:0];
				REG_TIMEOUT_TICKS: cfg_q.timeout_ticks      <= pwdata[TMO_W-1:0];
				REG_DISCH_TICKS:   cfg_q.discharge_ticks    <= pwdata[SMP_W-1:0];
				REG_SETTLE_TICKS:  cfg_q.settle_ticks       <= pwdata[SMP_W-1:0];
				REG_GAP_TICKS:     cfg_q.gap_ticks          <= pwdata[SMP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SAMPLE_COUNT:  prdata = APB_DW'(cfg_q.sample_count);
			REG_CALIB_COUNT:   prdata = APB_DW'(cfg_q.calib_sample_count);
			REG_TIMEOUT_TICKS: prdata = APB_DW'(cfg_q.timeout_ticks);
			REG_DISCH_TICKS:   prdata = APB_DW'(cfg_q.discharge_ticks);
			REG_SETTLE_TICKS:  prdata = APB_DW'(cfg_q.settle_ticks);
			REG_GAP_TICKS:     prdata = APB_DW'(cfg_q.gap_ticks);
			default:           prdata = '0;
		endcase
	end

endmodule

@@ design/rcts_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on rcts_pkg for the divisor width.
module rcts_div #(
	parameter int DVD_W = 45
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [DVD_W-1:0]           dividend,
	input  logic [rcts_pkg::SMP_W-1:0] divisor,
	output logic                       done,
	output logic [DVD_W-1:0]           quotient
);
	import rcts_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SMP_W-1:0] dsr_q;
	logic [SMP_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [SMP_W:0]   trial;

	assign trial    = {rem_q, quo_q[DVD_W-1]} - {1'b0, dsr_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[SMP_W]) begin
				rem_q <= trial[SMP_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[SMP_W-2:0], quo_q[DVD_W-1]};
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

endmodule

@@ design/rcts_ctrl.sv @@
// Tick sequencer of the RC charge-time sensor: phase state, sample
// accumulation, baseline and result logic, output register.
// Depends on rcts_pkg; drives the shared divider rcts_div.
module rcts_ctrl #(
	parameter int FRAC_BITS   = 8,
	parameter int COUNT_WIDTH = 20,
	parameter int DVD_W       = COUNT_WIDTH + 17 + FRAC_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rcts_pkg::cfg_t             cfg,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       sense_a,
	input  logic                       sense_b,
	input  logic                       start_req,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       charge_a,
	output logic                       charge_b,
	output logic                       discharge_a,
	output logic                       discharge_b,
	output logic                       busy_res,
	output logic                       result_valid,
	output logic                       calibrated,
	output logic [rcts_pkg::RES_W-1:0] result_value,
	output logic                       div_start,
	output logic [DVD_W-1:0]           div_dividend,
	output logic [rcts_pkg::SMP_W-1:0] div_divisor,
	input  logic                       div_done,
	input  logic [DVD_W-1:0]           div_quotient
);
	import rcts_pkg::*;

	localparam int CW    = COUNT_WIDTH;
	localparam int SMPL_W = CW + 1;
	localparam int ACC_W = CW + 17;
	localparam int SUM_W = DVD_W + 2;
	localparam int EXT_W = (CW > TMO_W) ? CW : TMO_W;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_DISCH  = 5'b00010,
		PH_SETTLE = 5'b00100,
		PH_CHARGE = 5'b01000,
		PH_GAP    = 5'b10000
	} phase_t;

	typedef enum logic [2:0] {
		SQ_IDLE = 3'b001,
		SQ_DIV  = 3'b010,
		SQ_EMIT = 3'b100
	} seq_t;

	seq_t              seq_q;
	phase_t            phase_q, ph_d;
	logic              ch_q, ch_d;
	logic              have_q;
	logic [CW-1:0]     cnt_q, cnt_d, cnt_inc;
	logic [SMP_W-1:0]  idx_q, idx_d, idx_inc;
	logic [ACC_W-1:0]  acc_q, acc_d, acc_add;
	logic [DVD_W-1:0]  avg_a_q, base_a_q, base_b_q;
	logic              res_valid_q;
	logic [RES_W-1:0]  res_value_q;
	logic              fin_d;

	logic              accept;
	logic              sense;
	logic [SMP_W-1:0]  n_raw, n_run;
	logic [EXT_W-1:0]  tmo_ext, cmax_ext;
	logic [CW-1:0]     tmo;
	logic [SMPL_W-1:0] smp;
	logic              cnt_done_d, cnt_done_s, cnt_done_g;

	logic [DVD_W:0]            diff_a, diff_b;
	logic [SUM_W-1:0]          sum;
	logic [SUM_W-RES_W:0]      sum_hi;
	logic [RES_W-1:0]          sat;

	logic              out_valid_q;
	logic              chg_a_q, chg_b_q, dis_a_q, dis_b_q, busy_q, rv_q, cal_q;
	logic [RES_W-1:0]  rval_q;

	assign accept   = in_valid & ~in_stall;
	assign in_stall = (seq_q != SQ_IDLE);

	assign sense    = ch_q ? sense_b : sense_a;
	assign n_raw    = have_q ? cfg.sample_count : cfg.calib_sample_count;
	assign n_run    = (n_raw == '0) ? SMP_W'(1) : n_raw;
	assign tmo_ext  = EXT_W'(cfg.timeout_ticks);
	assign cmax_ext = EXT_W'({CW{1'b1}});
	assign tmo      = (tmo_ext > cmax_ext) ? {CW{1'b1}} : tmo_ext[CW-1:0];
	assign cnt_inc  = cnt_q + CW'(1);
	assign idx_inc  = idx_q + SMP_W'(1);
	assign cnt_done_d = (cnt_inc >= CW'(cfg.discharge_ticks));
	assign cnt_done_s = (cnt_inc >= CW'(cfg.settle_ticks));
	assign cnt_done_g = (cnt_inc >= CW'(cfg.gap_ticks));
	assign smp      = sense ? (SMPL_W'(cnt_q) + SMPL_W'(1)) : SMPL_W'(tmo);
	assign acc_add  = acc_q + ACC_W'(smp);

	always_comb begin
		ph_d  = phase_q;
		cnt_d = cnt_q;
		ch_d  = ch_q;
		idx_d = idx_q;
		acc_d = acc_q;
		fin_d = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (start_req) begin
					ch_d  = 1'b0;
					idx_d = '0;
					acc_d = '0;
					ph_d  = PH_DISCH;
					cnt_d = '0;
				end
			end
			PH_DISCH: begin
				cnt_d = cnt_inc;
				if (cnt_done_d) begin
					ph_d  = (cfg.settle_ticks == '0) ? PH_CHARGE : PH_SETTLE;
					cnt_d = '0;
				end
			end
			PH_SETTLE: begin
				cnt_d = cnt_inc;
				if (cnt_done_s) begin
					ph_d  = PH_CHARGE;
					cnt_d = '0;
				end
			end
			PH_CHARGE: begin
				if (sense || cnt_q >= tmo) begin
					acc_d = acc_add;
					idx_d = idx_inc;
					cnt_d = '0;
					if (cfg.gap_ticks != '0) begin
						ph_d = PH_GAP;
					end else if (idx_inc >= n_run) begin
						fin_d = 1'b1;
					end else begin
						ph_d = PH_DISCH;
					end
				end else begin
					cnt_d = cnt_inc;
				end
			end
			PH_GAP: begin
				cnt_d = cnt_inc;
				if (cnt_done_g) begin
					cnt_d = '0;
					if (idx_q >= n_run) begin
						fin_d = 1'b1;
					end else begin
						ph_d = PH_DISCH;
					end
				end
			end
			default: begin
				ph_d  = PH_IDLE;
				cnt_d = '0;
				ch_d  = 1'b0;
			end
		endcase
	end

	assign div_start    = accept & fin_d;
	assign div_dividend = DVD_W'(acc_d) << FRAC_BITS;
	assign div_divisor  = n_run;

	assign diff_a = {1'b0, avg_a_q} - {1'b0, base_a_q};
	assign diff_b = {1'b0, div_quotient} - {1'b0, base_b_q};
	assign sum    = {diff_a[DVD_W], diff_a} + {diff_b[DVD_W], diff_b};
	assign sum_hi = sum[SUM_W-1:RES_W-1];

	always_comb begin
		if ((&sum_hi) || ~(|sum_hi)) begin
			sat = sum[RES_W-1:0];
		end else if (sum[SUM_W-1]) begin
			sat = {1'b1, {(RES_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(RES_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= SQ_IDLE;
			phase_q     <= PH_IDLE;
			ch_q        <= 1'b0;
			have_q      <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
			acc_q       <= '0;
			avg_a_q     <= '0;
			base_a_q    <= '0;
			base_b_q    <= '0;
			res_valid_q <= 1'b0;
			res_value_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (seq_q == SQ_EMIT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (seq_q)
				SQ_IDLE: begin
					if (accept) begin
						phase_q     <= ph_d;
						cnt_q       <= cnt_d;
						ch_q        <= ch_d;
						idx_q       <= idx_d;
						acc_q       <= acc_d;
						res_valid_q <= 1'b0;
						res_value_q <= '0;
						seq_q       <= fin_d ? SQ_DIV : SQ_EMIT;
					end
				end
				SQ_DIV: begin
					if (div_done) begin
						cnt_q <= '0;
						if (!ch_q) begin
							avg_a_q <= div_quotient;
							ch_q    <= 1'b1;
							idx_q   <= '0;
							acc_q   <= '0;
							phase_q <= PH_DISCH;
						end else begin
							phase_q <= PH_IDLE;
							ch_q    <= 1'b0;
							if (!have_q) begin
								base_a_q <= avg_a_q;
								base_b_q <= div_quotient;
								have_q   <= 1'b1;
							end else begin
								res_valid_q <= 1'b1;
								res_value_q <= sat;
							end
						end
						seq_q <= SQ_EMIT;
					end
				end
				SQ_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						seq_q <= SQ_IDLE;
					end
				end
				default: seq_q <= SQ_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (seq_q == SQ_EMIT && (!out_valid_q || !out_stall)) begin
			chg_a_q <= (phase_q == PH_CHARGE) && !ch_q;
			chg_b_q <= (phase_q == PH_CHARGE) && ch_q;
			dis_a_q <= (phase_q == PH_DISCH) && !ch_q;
			dis_b_q <= (phase_q == PH_DISCH) && ch_q;
			busy_q  <= (phase_q != PH_IDLE);
			rv_q    <= res_valid_q;
			cal_q   <= have_q;
			rval_q  <= res_value_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign charge_a     = chg_a_q;
	assign charge_b     = chg_b_q;
	assign discharge_a  = dis_a_q;
	assign discharge_b  = dis_b_q;
	assign busy_res     = busy_q;
	assign result_valid = rv_q;
	assign calibrated   = cal_q;
	assign result_value = rval_q;

endmodule

@@ design/rc_charge_time_sensor.sv @@
// Top level of the RC charge-time capacitance sensor.
// Depends on rcts_pkg, rcts_regs, rcts_div and rcts_ctrl.
//
//   channel   handshake            payload
//   input     in_valid / in_stall  sense_a, sense_b, start_req (one 1 MHz tick)
//   output    out_valid/ out_stall charge_a/b, discharge_a/b, busy_res,
//                                  result_valid, calibrated, result_value
//   config    APB psel/penable     paddr, pwdata, prdata, pready
//
// An accepted tick is registered and then loaded into the output register; a tick that
// ends a channel first waits for the bit-serial divider to form the channel average.
// in_stall is high from the cycle after an accepted transaction until its result
// enters the output register; a stalled output holds the block in that last step.
// Reset clears the run state, baselines and configuration to their defaults.
module rc_charge_time_sensor #(
	parameter int FRAC_BITS   = 8,
	parameter int COUNT_WIDTH = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         sense_a,
	input  logic                         sense_b,
	input  logic                         start_req,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         charge_a,
	output logic                         charge_b,
	output logic                         discharge_a,
	output logic                         discharge_b,
	output logic                         busy_res,
	output logic                         result_valid,
	output logic                         calibrated,
	output logic [rcts_pkg::RES_W-1:0]   result_value,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rcts_pkg::APB_AW-1:0]  paddr,
	input  logic [rcts_pkg::APB_DW-1:0]  pwdata,
	output logic [rcts_pkg::APB_DW-1:0]  prdata,
	output logic                         pready
);
	import rcts_pkg::*;

	localparam int DVD_W = COUNT_WIDTH + 17 + FRAC_BITS;

	cfg_t             cfg;
	logic             div_start;
	logic             div_done;
	logic [DVD_W-1:0] div_dividend;
	logic [DVD_W-1:0] div_quotient;
	logic [SMP_W-1:0] div_divisor;

	rcts_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rcts_div #(
		.DVD_W (DVD_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	rcts_ctrl #(
		.FRAC_BITS   (FRAC_BITS),
		.COUNT_WIDTH (COUNT_WIDTH),
		.DVD_W       (DVD_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sense_a      (sense_a),
		.sense_b      (sense_b),
		.start_req    (start_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.charge_a     (charge_a),
		.charge_b     (charge_b),
		.discharge_a  (discharge_a),
		.discharge_b  (discharge_b),
		.busy_res     (busy_res),
		.result_valid (result_valid),
		.calibrated   (calibrated),
		.result_value (result_value),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_quotient (div_quotient)
	);

endmodule

@@ design/rcts_checker.sv @@
// Port-level assertions for the RC charge-time sensor, bound to the top level.
// Depends on rcts_pkg and rc_charge_time_sensor.
module rcts_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       charge_a,
	input logic                       charge_b,
	input logic                       discharge_a,
	input logic                       discharge_b,
	input logic                       busy_res,
	input logic                       result_valid,
	input logic                       calibrated,
	input logic [rcts_pkg::RES_W-1:0] result_value
);
	import rcts_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value))
		else $error("output transaction dropped or changed while stalled");

	a_pin_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({charge_a, charge_b, discharge_a, discharge_b}) <= 1)
		else $error("more than one pin driven at once");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_valid |-> calibrated && !busy_res)
		else $error("result reported outside a finished calibrated run");

	a_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !result_valid |-> result_value == '0)
		else $error("result value nonzero without result_valid");

	a_pin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (charge_a || charge_b || discharge_a || discharge_b) |-> busy_res)
		else $error("pin driven while no run in progress");

endmodule

bind rc_charge_time_sensor rcts_checker u_rcts_checker (.*);

@@ bench/rc_charge_time_sensor_test.sv @@
// Self-checking bench for rc_charge_time_sensor: one tick per input transaction,
// pin states and readings predicted per tick and compared; registers set over APB.
// Depends on rcts_pkg and the design files of rc_charge_time_sensor.
`timescale 1ns / 100ps

module rc_charge_time_sensor_test;
	import rcts_pkg::*;

	localparam int FRAC = 8;
	localparam longint VAL_MAX = 536870911;
	localparam longint VAL_MIN = -536870912;
	localparam int RANDOM_TICKS = 2000;

	typedef enum logic [2:0] {PH_IDLE, PH_DISCH, PH_SETTLE, PH_CHARGE, PH_GAP} sensor_phase_t;

	typedef struct packed {
		logic             charge_a;
		logic             charge_b;
		logic             discharge_a;
		logic             discharge_b;
		logic             busy;
		logic             ready;
		logic             calibrated;
		logic [RES_W-1:0] value;
	} pin_state_t;

	typedef struct packed {
		logic       sa;
		logic       sb;
		logic       st;
		logic       typed;
		pin_state_t want;
	} tick_row_t;

	localparam pin_state_t AT_RESET = '0;
	localparam pin_state_t FIRST_DISCH = '{discharge_a: 1'b1, busy: 1'b1, default: '0};
	localparam pin_state_t CALIB_DONE = '{calibrated: 1'b1, default: '0};
	localparam pin_state_t FIRST_READING =
		'{ready: 1'b1, calibrated: 1'b1, value: RES_W'(-768), default: '0};

	localparam tick_row_t DIR_ROWS [23] = '{
		'{1'b0, 1'b0, 1'b0, 1'b1, AT_RESET},
		'{1'b1, 1'b1, 1'b1, 1'b1, FIRST_DISCH},
		'{1'b0, 1'b0, 1'b0, 1'b0, AT_RESET},
		'{1'b0, 1'b0, 1'b1, 1'b0, AT_RESET},
		'{1'b0, 1'b0, 1'b0, 1'b0, AT_RESET},
		'{1'b0, 1'b1, 1'b0, 1'b0, AT_RESET},
		'{1'b0, 1'b0, 1'b0, 1'b0, AT_RESET},
		'{1'b0, 1'b0, 1'b0, 1'b0, AT_RESET},
		'{1'b0, 1'b0, 1'b0, 1'b0, AT_RESET},
		'{1'b0, 1'b0, 1'b0, 1'b0, AT_RESET},
		'{1'b0, 1'b0, 1'b0, 1'b0, AT_RESET},
		'{1'b1, 1'b0, 1'b0, 1'b0, AT_RESET},
		'{1'b0, 1'b1, 1'b0, 1'b0, AT_RESET},
		'{1'b0, 1'b0, 1'b0, 1'b1, CALIB_DONE},
		'{1'b0, 1'b0, 1'b1, 1'b0, AT_RESET},
		'{1'b0, 1'b0, 1'b0, 1'b0, AT_RESET},
		'{1'b0, 1'b0, 1'b0, 1'b0, AT_RESET},
		'{1'b1, 1'b0, 1'b0, 1'b0, AT_RESET},
		'{1'b0, 1'b0, 1'b0, 1'b0, AT_RESET},
		'{1'b0, 1'b0, 1'b0, 1'b0, AT_RESET},
		'{1'b0, 1'b0, 1'b0, 1'b0, AT_RESET},
		'{1'b0, 1'b1, 1'b0, 1'b0, AT_RESET},
		'{1'b0, 1'b0, 1'b0, 1'b1, FIRST_READING}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               sense_a;
	logic               sense_b;
	logic               start_req;
	logic               out_valid;
	logic               out_stall;
	logic               charge_a;
	logic               charge_b;
	logic               discharge_a;
	logic               discharge_b;
	logic               busy_res;
	logic               result_valid;
	logic               calibrated;
	logic [RES_W-1:0]   result_value;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [APB_AW-1:0]  paddr;
	logic [APB_DW-1:0]  pwdata;
	logic [APB_DW-1:0]  prdata;
	logic               pready;

	cfg_t               regs_now;
	sensor_phase_t      ph;
	logic               chan;
	logic               have_base;
	logic [TMO_W-1:0]   ph_cnt;
	logic [SMP_W-1:0]   smp_idx;
	logic [36:0]        acc;
	logic [63:0]        avg_a;
	logic [63:0]        base_a;
	logic [63:0]        base_b;
	logic               reading_due;
	logic [RES_W-1:0]   reading;

	pin_state_t         pin_states_due [$];
	bit                 no_gaps = 1'b0;
	int                 n_bad = 0;
	int                 n_ticks = 0;
	int                 n_checked = 0;
	int                 n_readings = 0;
	int                 n_writes = 0;

	rc_charge_time_sensor i_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	function automatic void begin_channel(input logic ch);
		chan = ch;
		smp_idx = '0;
		acc = '0;
		ph = PH_DISCH;
		ph_cnt = '0;
	endfunction

	function automatic void next_sample_or_close();
		logic [SMP_W-1:0] n;
		logic [63:0] avg;
		longint dev;
		n = have_base ? regs_now.sample_count : regs_now.calib_sample_count;
		if (n == 0)
			n = SMP_W'(1);
		if (smp_idx < n) begin
			ph = PH_DISCH;
			ph_cnt = '0;
		end else begin
			avg = (64'(acc) << FRAC) / 64'(n);
			if (!chan) begin
				avg_a = avg;
				begin_channel(1'b1);
			end else begin
				ph = PH_IDLE;
				ph_cnt = '0;
				chan = 1'b0;
				if (!have_base) begin
					base_a = avg_a;
					base_b = avg;
					have_base = 1'b1;
				end else begin
					dev = (longint'(avg_a) - longint'(base_a)) + (longint'(avg) - longint'(base_b));
					if (dev > VAL_MAX)
						dev = VAL_MAX;
					if (dev < VAL_MIN)
						dev = VAL_MIN;
					reading_due = 1'b1;
					reading = dev[RES_W-1:0];
				end
			end
		end
	endfunction

	function automatic void end_sample(input logic [TMO_W:0] amount);
		acc = acc + 37'(amount);
		smp_idx = smp_idx + 1'b1;
		if (regs_now.gap_ticks == 0) begin
			next_sample_or_close();
		end else begin
			ph = PH_GAP;
			ph_cnt = '0;
		end
	endfunction

	function automatic pin_state_t step_sensor(input logic sa, input logic sb, input logic st);
		pin_state_t o;
		logic sense;
		sense = chan ? sb : sa;
		reading_due = 1'b0;
		reading = '0;
		case (ph)
			PH_IDLE: begin
				if (st)
					begin_channel(1'b0);
			end
			PH_DISCH: begin
				ph_cnt = ph_cnt + 1'b1;
				if (ph_cnt >= regs_now.discharge_ticks) begin
					ph = (regs_now.settle_ticks == 0) ? PH_CHARGE : PH_SETTLE;
					ph_cnt = '0;
				end
			end
			PH_SETTLE: begin
				ph_cnt = ph_cnt + 1'b1;
				if (ph_cnt >= regs_now.settle_ticks) begin
					ph = PH_CHARGE;
					ph_cnt = '0;
				end
			end
			PH_CHARGE: begin
				if (sense)
					end_sample({1'b0, ph_cnt} + 1'b1);
				else if (ph_cnt >= regs_now.timeout_ticks)
					end_sample({1'b0, regs_now.timeout_ticks});
				else
					ph_cnt = ph_cnt + 1'b1;
			end
			PH_GAP: begin
				ph_cnt = ph_cnt + 1'b1;
				if (ph_cnt >= regs_now.gap_ticks)
					next_sample_or_close();
			end
			default: begin
				ph = PH_IDLE;
				ph_cnt = '0;
				chan = 1'b0;
			end
		endcase
		o.charge_a = (ph == PH_CHARGE) && !chan;
		o.charge_b = (ph == PH_CHARGE) && chan;
		o.discharge_a = (ph == PH_DISCH) && !chan;
		o.discharge_b = (ph == PH_DISCH) && chan;
		o.busy = (ph != PH_IDLE);
		o.ready = reading_due;
		o.calibrated = have_base;
		o.value = reading;
		return o;
	endfunction

	task automatic flag_mismatch(input string msg);
		n_bad++;
		if (n_bad <= 40)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	task automatic compare_pin(input string name, input logic [RES_W-1:0] got,
			input logic [RES_W-1:0] want);
		if (got !== want)
			flag_mismatch($sformatf("tick %0d %s got %0h want %0h", n_checked, name, got, want));
	endtask

	task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
			input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = APB_AW'({idx, 2'b00});
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] val);
		logic [APB_DW-1:0] ignored;
		apb_access(1'b1, idx, val, ignored);
		case (idx)
			REG_SAMPLE_COUNT: regs_now.sample_count = val[SMP_W-1:0];
			REG_CALIB_COUNT: regs_now.calib_sample_count = val[SMP_W-1:0];
			REG_TIMEOUT_TICKS: regs_now.timeout_ticks = val[TMO_W-1:0];
			REG_DISCH_TICKS: regs_now.discharge_ticks = val[SMP_W-1:0];
			REG_SETTLE_TICKS: regs_now.settle_ticks = val[SMP_W-1:0];
			REG_GAP_TICKS: regs_now.gap_ticks = val[SMP_W-1:0];
			default: ;
		endcase
		n_writes++;
	endtask

	task automatic check_reg(input logic [REG_IDX_W-1:0] idx);
		logic [APB_DW-1:0] got;
		logic [APB_DW-1:0] want;
		apb_access(1'b0, idx, '0, got);
		case (idx)
			REG_SAMPLE_COUNT: want = APB_DW'(regs_now.sample_count);
			REG_CALIB_COUNT: want = APB_DW'(regs_now.calib_sample_count);
			REG_TIMEOUT_TICKS: want = APB_DW'(regs_now.timeout_ticks);
			REG_DISCH_TICKS: want = APB_DW'(regs_now.discharge_ticks);
			REG_SETTLE_TICKS: want = APB_DW'(regs_now.settle_ticks);
			REG_GAP_TICKS: want = APB_DW'(regs_now.gap_ticks);
			default: want = '0;
		endcase
		if (got !== want)
			flag_mismatch($sformatf("register %0d reads %0h, holds %0h", idx, got, want));
	endtask

	task automatic send_tick(input logic sa, input logic sb, input logic st, input logic typed,
			input pin_state_t want);
		int idle;
		pin_state_t due;
		idle = no_gaps ? 0 : pick_gap();
		repeat (idle) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		sense_a = sa;
		sense_b = sb;
		start_req = st;
		do @(posedge clk); while (in_stall !== 1'b0);
		due = step_sensor(sa, sb, st);
		pin_states_due.push_back(typed ? want : due);
		n_ticks++;
	endtask

	task automatic random_tick(input logic allow_start);
		send_tick($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
			allow_start && ($urandom_range(0, 2) == 0), 1'b0, AT_RESET);
	endtask

	task automatic quiesce(input int extra);
		@(negedge clk);
		in_valid = 1'b0;
		while (pin_states_due.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			repeat (($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 12)) begin
				@(negedge clk);
				out_stall = 1'b0;
			end
			repeat (pick_gap()) begin
				@(negedge clk);
				out_stall = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		pin_state_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			n_checked++;
			if (pin_states_due.size() == 0) begin
				flag_mismatch("transaction out with none pending");
			end else begin
				want = pin_states_due.pop_front();
				compare_pin("charge_a", RES_W'(charge_a), RES_W'(want.charge_a));
				compare_pin("charge_b", RES_W'(charge_b), RES_W'(want.charge_b));
				compare_pin("discharge_a", RES_W'(discharge_a), RES_W'(want.discharge_a));
				compare_pin("discharge_b", RES_W'(discharge_b), RES_W'(want.discharge_b));
				compare_pin("busy_res", RES_W'(busy_res), RES_W'(want.busy));
				compare_pin("result_valid", RES_W'(result_valid), RES_W'(want.ready));
				compare_pin("calibrated", RES_W'(calibrated), RES_W'(want.calibrated));
				compare_pin("result_value", result_value, want.value);
				if (want.ready)
					n_readings++;
			end
		end
	end

	initial begin
		#30_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int n_random;
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sense_a = 1'b0;
		sense_b = 1'b0;
		start_req = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		n_random = 0;
		regs_now = '{sample_count: RST_SAMPLE_COUNT, calib_sample_count: RST_CALIB_COUNT,
			timeout_ticks: RST_TIMEOUT_TICKS, discharge_ticks: RST_DISCH_TICKS,
			settle_ticks: RST_SETTLE_TICKS, gap_ticks: RST_GAP_TICKS};
		ph = PH_IDLE;
		chan = 1'b0;
		have_base = 1'b0;
		ph_cnt = '0;
		smp_idx = '0;
		acc = '0;
		avg_a = '0;
		base_a = '0;
		base_b = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = REG_SAMPLE_COUNT; i <= REG_GAP_TICKS; i++)
			check_reg(REG_IDX_W'(i));
		write_reg(REG_SAMPLE_COUNT, 1);
		write_reg(REG_CALIB_COUNT, 1);
		write_reg(REG_TIMEOUT_TICKS, 3);
		write_reg(REG_DISCH_TICKS, 1);
		write_reg(REG_SETTLE_TICKS, 1);
		write_reg(REG_GAP_TICKS, 1);
		foreach (DIR_ROWS[i])
			send_tick(DIR_ROWS[i].sa, DIR_ROWS[i].sb, DIR_ROWS[i].st, DIR_ROWS[i].typed,
				DIR_ROWS[i].want);

		// drain the run so full-scale settings never start a measurement
		while (ph != PH_IDLE)
			random_tick(1'b0);
		quiesce(4);
		for (int i = REG_SAMPLE_COUNT; i <= REG_GAP_TICKS; i++)
			write_reg(REG_IDX_W'(i), '1);
		for (int i = REG_SAMPLE_COUNT; i <= REG_GAP_TICKS; i++)
			check_reg(REG_IDX_W'(i));
		repeat (8) random_tick(1'b0);
		quiesce(4);
		for (int i = REG_SAMPLE_COUNT; i <= REG_GAP_TICKS; i++)
			write_reg(REG_IDX_W'(i), '0);
		for (int i = REG_SAMPLE_COUNT; i <= REG_GAP_TICKS; i++)
			check_reg(REG_IDX_W'(i));
		repeat (80) random_tick(1'b1);

		while (n_random < RANDOM_TICKS) begin
			quiesce(4);
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1))
				write_reg(REG_SAMPLE_COUNT, $urandom_range(0, 4));
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_CALIB_COUNT, $urandom_range(0, 65535));
			case ($urandom_range(0, 5))
				0: write_reg(REG_TIMEOUT_TICKS, 0);
				1: write_reg(REG_TIMEOUT_TICKS, '1);
				default: write_reg(REG_TIMEOUT_TICKS, $urandom_range(1, 12));
			endcase
			if ($urandom_range(0, 1))
				write_reg(REG_DISCH_TICKS, $urandom_range(0, 4));
			if ($urandom_range(0, 1))
				write_reg(REG_SETTLE_TICKS, $urandom_range(0, 3));
			if ($urandom_range(0, 1))
				write_reg(REG_GAP_TICKS, $urandom_range(0, 3));
			check_reg(REG_IDX_W'($urandom_range(REG_SAMPLE_COUNT, REG_GAP_TICKS)));
			n = $urandom_range(20, 150);
			repeat (n) random_tick(1'b1);
			n_random += n;
		end
		quiesce(60);

		$display("Ran %0d ticks through calibration, zero and full-scale settings", n_ticks);
		$display("and random register changes; %0d readings, %0d register writes.",
			n_readings, n_writes);
		if (n_bad == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
design/rcts_pkg.sv
design/rcts_regs.sv
design/rcts_div.sv
design/rcts_ctrl.sv
design/rc_charge_time_sensor.sv
design/rcts_checker.sv
bench/rc_charge_time_sensor_test.sv
